// ----- rtl/digit_image_despeckle_filter_macros.svh -----
// Assertion helpers used by the filter RTL.
`ifndef DIGIT_IMAGE_DESPECKLE_FILTER_MACROS_SVH
`define DIGIT_IMAGE_DESPECKLE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define DIDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("despeckle filter assertion failed");
// Next-cycle implication, disabled in reset.
`define DIDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("despeckle filter assertion failed");
`else
`define DIDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DIDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/dids_pkg.sv -----
package dids_pkg;

  localparam int DIDS_MAX_COLS   = 64;
  localparam int DIDS_MAX_ROWS   = 1023;
  localparam int DIDS_DIGIT_W    = 4;
  localparam int DIDS_GLYPH_W    = 7;
  localparam int DIDS_DATA_W     = 32;
  localparam int DIDS_PADDR_W    = 3;
  localparam int DIDS_ROWS_RESET = 20;
  localparam int DIDS_COLS_RESET = 30;
  localparam int DIDS_SIZE_MIN   = 2;

  // register index, taken from paddr[2]
  localparam logic DIDS_REG_ROWS = 1'b0;
  localparam logic DIDS_REG_COLS = 1'b1;

  typedef logic [DIDS_DIGIT_W-1:0] digit_t;

  localparam digit_t DIDS_DIGIT_MAX = 4'd9;

  // floor(x / 3) == (x * 43) >> 7 for x up to 36
  localparam int DIDS_THIRD_MUL   = 43;
  localparam int DIDS_THIRD_SHIFT = 7;

  localparam logic [DIDS_GLYPH_W-1:0] DIDS_GLYPH_MAP [10] = '{
    7'd32, 7'd46, 7'd39, 7'd58, 7'd126, 7'd42, 7'd61, 7'd64, 7'd37, 7'd35
  };

  function automatic logic [DIDS_GLYPH_W-1:0] dids_glyph(digit_t d);
    digit_t idx;
    idx = (d > DIDS_DIGIT_MAX) ? DIDS_DIGIT_MAX : d;
    return DIDS_GLYPH_MAP[idx];
  endfunction

  // Average of the differing neighbors when more than one differs.
  function automatic digit_t dids_smooth(digit_t centre,
                                         logic up_p, digit_t up_v,
                                         logic dn_p, digit_t dn_v,
                                         logic lf_p, digit_t lf_v,
                                         logic rt_p, digit_t rt_v);
    logic [5:0]  sum;
    logic [2:0]  cnt;
    logic [10:0] prod;
    digit_t      res;
    sum  = '0;
    cnt  = '0;
    prod = '0;
    if (up_p && up_v != centre) begin
      sum = sum + 6'(up_v);
      cnt = cnt + 3'd1;
    end
    if (dn_p && dn_v != centre) begin
      sum = sum + 6'(dn_v);
      cnt = cnt + 3'd1;
    end
    if (lf_p && lf_v != centre) begin
      sum = sum + 6'(lf_v);
      cnt = cnt + 3'd1;
    end
    if (rt_p && rt_v != centre) begin
      sum = sum + 6'(rt_v);
      cnt = cnt + 3'd1;
    end
    case (cnt) inside
      3'd0, 3'd1: res = centre;
      3'd2: res = digit_t'(sum >> 1);
      3'd3: begin
        prod = 11'(sum) * 11'(DIDS_THIRD_MUL);
        res  = digit_t'(prod >> DIDS_THIRD_SHIFT);
      end
      default: res = digit_t'(sum >> 2);
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/digit_image_despeckle_filter.sv -----
// Despeckle filter for a raster stream of digit pixels.
// in_* channel: one pixel (0..9, larger values saturate to 9) per transfer,
// row by row. out_* channel: filtered pixels with row/column index, glyph
// code and row/frame end flags. Results for a row appear while the next row
// streams in; the last row is flushed as it arrives, the final pixel of the
// frame carrying frame_end.
// Each item passes the line store reads (a first read pair at the transfer,
// a second pair in ST_RD2, on a two-read-port memory), a compute step in
// ST_CALC and then ST_EMIT, which moves its results (0 to 3) into the output
// register one at a time. The next pixel is taken once the last result of
// the current one has moved into the output register.
// Frame size comes from the APB registers rows_in_use (0x0) and cols_in_use
// (0x4), clamped to 2..MAX_ROWS and 2..MAX_COLS.
// Reset clears the row/column counters and loads 20 rows by 30 columns; the
// line store is not cleared; only values that this frame wrote are used.
// A stalled receiver holds the output register; pending results of the
// current pixel wait behind it and in_ready stays low until they drain.
`include "digit_image_despeckle_filter_macros.svh"

module digit_image_despeckle_filter
  import dids_pkg::*;
#(
  parameter int MAX_COLS = DIDS_MAX_COLS,
  parameter int MAX_ROWS = DIDS_MAX_ROWS,
  localparam int COL_W = $clog2(MAX_COLS),
  localparam int ROW_W = $clog2(MAX_ROWS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [DIDS_PADDR_W-1:0] paddr,
  input  logic [DIDS_DATA_W-1:0]  pwdata,
  output logic [DIDS_DATA_W-1:0]  prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DIDS_DIGIT_W-1:0] in_pixel_digit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic [DIDS_DIGIT_W-1:0] out_smoothed_digit,
  output logic [DIDS_GLYPH_W-1:0] out_glyph_code,
  output logic                    out_row_end,
  output logic                    out_frame_end
);

  localparam int ROWCFG_W = $clog2(MAX_ROWS + 1);
  localparam int COLCFG_W = $clog2(MAX_COLS + 1);
  localparam int DEPTH    = 3 * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD2  = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  function automatic logic [ADDR_W-1:0] line_addr(logic [1:0] slot,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  logic [ROWCFG_W-1:0] rows_lim;
  logic [COLCFG_W-1:0] cols_lim;

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [1:0]       slot_r;
  logic [1:0]       prev_slot, prev2_slot;
  logic             accept;
  logic             last_col_now, last_row_now;
  digit_t           px_sat;

  logic [ROW_W-1:0] it_row_r;
  logic [COL_W-1:0] it_col_r;
  logic             it_lc_r, it_lr_r;
  logic [1:0]       it_prev_r, it_prev2_r;
  digit_t           h1_r, h2_r, h3_r;
  digit_t           p_left_r, p_ctr_r;

  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  digit_t            rd_data_a, rd_data_b;

  digit_t           res_a, res_b, res_c;
  logic [2:0]       pend_r, pend_nxt, calc_mask;
  logic [ROW_W-1:0] pend_row_r [3];
  logic [COL_W-1:0] pend_col_r [3];
  digit_t           pend_dig_r [3];
  logic [2:0]       pend_re_r, pend_fe_r;
  logic [1:0]       sel_idx;
  logic [2:0]       sel_mask;
  logic             load_out;

  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic [COL_W-1:0]        out_col_r;
  digit_t                  out_digit_r;
  logic [DIDS_GLYPH_W-1:0] out_glyph_r;
  logic                    out_row_end_r, out_frame_end_r;

  dids_cfg_regs #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .rows_lim (rows_lim),
    .cols_lim (cols_lim)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign px_sat   = (in_pixel_digit > DIDS_DIGIT_MAX) ? DIDS_DIGIT_MAX : in_pixel_digit;

  assign last_col_now = (COLCFG_W'(col_cnt_r) + COLCFG_W'(1)) >= cols_lim;
  assign last_row_now = (ROWCFG_W'(row_cnt_r) + ROWCFG_W'(1)) >= rows_lim;

  always_comb begin
    unique case (slot_r)
      SLOT_0:  begin prev_slot = SLOT_2; prev2_slot = SLOT_1; end
      SLOT_1:  begin prev_slot = SLOT_0; prev2_slot = SLOT_2; end
      default: begin prev_slot = SLOT_1; prev2_slot = SLOT_0; end
    endcase
  end

  // First read pair at the transfer, second pair in the cycle after it (ST_RD2).
  always_comb begin
    wr_addr = line_addr(slot_r, col_cnt_r);
    if (state_r == ST_IDLE) begin
      rd_addr_a = line_addr(prev_slot, col_cnt_r - COL_W'(1));
      rd_addr_b = line_addr(prev_slot, col_cnt_r);
    end else begin
      rd_addr_a = line_addr(it_prev_r, it_col_r + COL_W'(1));
      rd_addr_b = line_addr(it_prev2_r, it_col_r);
    end
  end

  dids_line_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (px_sat),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      slot_r    <= SLOT_0;
    end else if (accept) begin
      if (last_col_now) begin
        col_cnt_r <= '0;
        if (last_row_now) begin
          row_cnt_r <= '0;
          slot_r    <= SLOT_0;
        end else begin
          row_cnt_r <= row_cnt_r + ROW_W'(1);
          slot_r    <= (slot_r == SLOT_2) ? SLOT_0 : slot_r + 2'd1;
        end
      end else begin
        col_cnt_r <= col_cnt_r + COL_W'(1);
      end
    end
  end

  // Item context; h1..h3 hold this pixel and the two accepted before it.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_row_r   <= row_cnt_r;
      it_col_r   <= col_cnt_r;
      it_lc_r    <= last_col_now;
      it_lr_r    <= last_row_now;
      it_prev_r  <= prev_slot;
      it_prev2_r <= prev2_slot;
      h1_r       <= px_sat;
      h2_r       <= h1_r;
      h3_r       <= h2_r;
    end
    if (state_r == ST_RD2) begin
      p_left_r <= rd_data_a;
      p_ctr_r  <= rd_data_b;
    end
  end

  // rd_data_a: above-right of the previous row, rd_data_b: two rows up
  assign res_a = dids_smooth(p_ctr_r,
                             it_row_r > ROW_W'(1), rd_data_b,
                             1'b1, h1_r,
                             it_col_r != '0, p_left_r,
                             !it_lc_r, rd_data_a);
  assign res_b = dids_smooth(h2_r,
                             1'b1, p_left_r,
                             1'b0, '0,
                             it_col_r > COL_W'(1), h3_r,
                             1'b1, h1_r);
  assign res_c = dids_smooth(h1_r,
                             1'b1, p_ctr_r,
                             1'b0, '0,
                             it_col_r != '0, h2_r,
                             1'b0, '0);

  assign calc_mask = {it_lr_r & it_lc_r, it_lr_r & (it_col_r != '0), it_row_r != '0};

  always_comb begin
    if (pend_r[0]) begin
      sel_idx  = 2'd0;
      sel_mask = 3'b001;
    end else if (pend_r[1]) begin
      sel_idx  = 2'd1;
      sel_mask = 3'b010;
    end else begin
      sel_idx  = 2'd2;
      sel_mask = 3'b100;
    end
  end

  assign load_out = (state_r == ST_EMIT) && (pend_r != 3'b000) &&
                    (!out_valid_r || out_ready);

  always_comb begin
    pend_nxt = pend_r;
    if (state_r == ST_CALC) begin
      pend_nxt = calc_mask;
    end else if (load_out) begin
      pend_nxt = pend_r & ~sel_mask;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_CALC;
      ST_CALC: state_nxt = (calc_mask != 3'b000) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (load_out && pend_nxt == 3'b000) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 3'b000;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      pend_row_r[0] <= it_row_r - ROW_W'(1);
      pend_col_r[0] <= it_col_r;
      pend_dig_r[0] <= res_a;
      pend_row_r[1] <= it_row_r;
      pend_col_r[1] <= it_col_r - COL_W'(1);
      pend_dig_r[1] <= res_b;
      pend_row_r[2] <= it_row_r;
      pend_col_r[2] <= it_col_r;
      pend_dig_r[2] <= res_c;
      pend_re_r     <= {1'b1, 1'b0, it_lc_r};
      pend_fe_r     <= 3'b100;
    end
  end

  // Output register: hold while stalled, advance on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row_r       <= pend_row_r[sel_idx];
      out_col_r       <= pend_col_r[sel_idx];
      out_digit_r     <= pend_dig_r[sel_idx];
      out_glyph_r     <= dids_glyph(pend_dig_r[sel_idx]);
      out_row_end_r   <= pend_re_r[sel_idx];
      out_frame_end_r <= pend_fe_r[sel_idx];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_smoothed_digit = out_digit_r;
  assign out_glyph_code     = out_glyph_r;
  assign out_row_end        = out_row_end_r;
  assign out_frame_end      = out_frame_end_r;

  `DIDS_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_r == ST_IDLE, pend_r == 3'b000)
  `DIDS_ASSERT_NXT(a_accept_to_rd2, clk, rst_n, in_valid && in_ready, state_r == ST_RD2)
  `DIDS_ASSERT_IMP(a_fe_is_re, clk, rst_n, out_valid_r && out_frame_end_r, out_row_end_r)
  `DIDS_ASSERT_IMP(a_digit_range, clk, rst_n, out_valid_r, out_digit_r <= DIDS_DIGIT_MAX)

endmodule

// ----- rtl/dids_cfg_regs.sv -----
module dids_cfg_regs
  import dids_pkg::*;
#(
  parameter int MAX_ROWS = DIDS_MAX_ROWS,
  parameter int MAX_COLS = DIDS_MAX_COLS,
  localparam int ROWCFG_W = $clog2(MAX_ROWS + 1),
  localparam int COLCFG_W = $clog2(MAX_COLS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [DIDS_PADDR_W-1:0] paddr,
  input  logic [DIDS_DATA_W-1:0]  pwdata,
  output logic [DIDS_DATA_W-1:0]  prdata,
  output logic                    pready,
  output logic [ROWCFG_W-1:0]     rows_lim,
  output logic [COLCFG_W-1:0]     cols_lim
);

  logic [ROWCFG_W-1:0] rows_r;
  logic [COLCFG_W-1:0] cols_r;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWCFG_W'(DIDS_ROWS_RESET);
      cols_r <= COLCFG_W'(DIDS_COLS_RESET);
    end else if (wr_en) begin
      unique case (paddr[2])
        DIDS_REG_ROWS: rows_r <= pwdata[ROWCFG_W-1:0];
        DIDS_REG_COLS: cols_r <= pwdata[COLCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      DIDS_REG_ROWS: prdata = DIDS_DATA_W'(rows_r);
      DIDS_REG_COLS: prdata = DIDS_DATA_W'(cols_r);
      default:       prdata = '0;
    endcase
  end

  // clamp out-of-range sizes
  always_comb begin
    if (rows_r < ROWCFG_W'(DIDS_SIZE_MIN)) begin
      rows_lim = ROWCFG_W'(DIDS_SIZE_MIN);
    end else if (rows_r > ROWCFG_W'(MAX_ROWS)) begin
      rows_lim = ROWCFG_W'(MAX_ROWS);
    end else begin
      rows_lim = rows_r;
    end
    if (cols_r < COLCFG_W'(DIDS_SIZE_MIN)) begin
      cols_lim = COLCFG_W'(DIDS_SIZE_MIN);
    end else if (cols_r > COLCFG_W'(MAX_COLS)) begin
      cols_lim = COLCFG_W'(MAX_COLS);
    end else begin
      cols_lim = cols_r;
    end
  end

endmodule

// ----- rtl/dids_line_store.sv -----
module dids_line_store
  import dids_pkg::*;
#(
  parameter int DEPTH  = 3 * DIDS_MAX_COLS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  digit_t            wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output digit_t            rd_data_a,
  output digit_t            rd_data_b
);

  digit_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
